// ===== rtl/core/fault_record_table_top_macros.svh =====
// Assertion helpers for the checker of this block.
`ifndef FAULT_RECORD_TABLE_TOP_MACROS_SVH
`define FAULT_RECORD_TABLE_TOP_MACROS_SVH

// Clocked assertion, off while reset is low.
`define FRT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form of the above.
`define FRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  `FRT_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/frt_pkg.sv =====
package frt_pkg;

  localparam int SLOTS_DEF = 16;

  localparam logic [1:0] OP_RAISE   = 2'd0;
  localparam logic [1:0] OP_CLEAR   = 2'd1;
  localparam logic [1:0] OP_RDFIRST = 2'd2;
  localparam logic [1:0] OP_RDSLOT  = 2'd3;

  localparam logic [2:0]  UNCLR_RST = 3'd3;
  localparam logic [31:0] SEQ_MAX   = 32'hFFFF_FFFF;

  // identity fields sit in the top bits of a record
  localparam int ID_W = 8 + 16 + 16 + 3 + 32 + 32 + 64 + 32;

  typedef struct packed {
    logic [7:0]  source;
    logic [15:0] code;
    logic [15:0] site;
    logic [2:0]  severity;
    logic [31:0] epoch;
    logic [31:0] parent;
    logic [63:0] args;
    logic [31:0] arg3;
    logic [31:0] seq;
    logic [31:0] occ;
    logic [31:0] lctl;
    logic [31:0] lts;
  } rec_t;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic step;
    logic append;
    logic clr_end;
    logic fail;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       code_zero;
    logic       empty;
    logic       last;
    logic       hit;
    logic       slot_ok;
    logic       first_zero;
    logic       out_free;
  } sts_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == SEQ_MAX) ? v : v + 32'd1;
  endfunction

endpackage

// ===== rtl/core/frt_ram.sv =====
module frt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/frt_ctrl.sv =====
module frt_ctrl
  import frt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_CMP    = 3'd3;
  localparam logic [2:0] S_APPEND = 3'd4;
  localparam logic [2:0] S_CLREND = 3'd5;
  localparam logic [2:0] S_FAIL   = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        case (sts.op)
          OP_RAISE: begin
            if (sts.code_zero) begin
              state_nxt = S_FAIL;
            end else begin
              cmd.scan_init = 1'b1;
              state_nxt     = sts.empty ? S_APPEND : S_RD;
            end
          end
          OP_CLEAR: begin
            cmd.scan_init = 1'b1;
            state_nxt     = sts.empty ? S_CLREND : S_RD;
          end
          OP_RDFIRST: begin
            if (sts.first_zero || sts.empty) begin
              state_nxt = S_FAIL;
            end else begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_RD;
            end
          end
          default: begin
            state_nxt = sts.slot_ok ? S_RD : S_FAIL;
          end
        endcase
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.step = 1'b1;
        case (sts.op)
          OP_RAISE:   state_nxt = sts.hit ? S_FIN : (sts.last ? S_APPEND : S_RD);
          OP_CLEAR:   state_nxt = sts.last ? S_CLREND : S_RD;
          OP_RDFIRST: state_nxt = sts.hit ? S_FIN : (sts.last ? S_FAIL : S_RD);
          default:    state_nxt = S_FIN;
        endcase
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_FIN;
      end
      S_CLREND: begin
        cmd.clr_end = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FAIL: begin
        cmd.fail  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/frt_dp.sv =====
module frt_dp
  import frt_pkg::*;
#(
  parameter int RECORD_SLOTS = SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cmd_t         cmd,
  output sts_t         sts,
  input  logic [2:0]   unclr,
  input  logic [1:0]   in_op,
  input  logic [303:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         out_ok,
  output logic [239:0] out_data
);

  localparam int IW = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;
  localparam int CW = $clog2(RECORD_SLOTS + 1);
  localparam int RW = $bits(rec_t);

  logic [1:0]  op_r;
  rec_t        item_r;
  logic [31:0] target_r;
  logic [CW-1:0] used_r, idx_r, w_r;
  logic [31:0] drop_r, next_r, first_r, rmin_r, kept0_r;
  logic        root_r, changed_r;
  rec_t        res_r;
  logic        res_ok_r;
  logic        out_valid_r, out_ok_r;
  logic [239:0] out_data_r;

  rec_t          rdata, upd, fresh, wdata;
  logic [RW-1:0] rdata_raw;
  logic          we, match, remove, seq_hit, full;
  logic [IW-1:0] waddr, raddr;

  frt_ram #(.WIDTH(RW), .DEPTH(RECORD_SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rdata = rec_t'(rdata_raw);
  assign raddr = (op_r == OP_RDSLOT) ? target_r[IW-1:0] : idx_r[IW-1:0];
  assign full  = ({1'b0, used_r} >= (CW+1)'(RECORD_SLOTS));

  assign match   = (rdata_raw[RW-1 -: ID_W] == item_r[RW-1 -: ID_W]);
  assign remove  = ((target_r == 32'd0) || (target_r == rdata.seq)) &&
                   (rdata.severity != unclr);
  assign seq_hit = (rdata.seq == first_r);

  always_comb begin
    upd      = rdata;
    upd.occ  = sat_inc(rdata.occ);
    upd.lctl = item_r.lctl;
    upd.lts  = item_r.lts;
    fresh     = item_r;
    fresh.seq = next_r;
    fresh.occ = 32'd1;
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_r[IW-1:0];
    wdata = upd;
    if (cmd.step && op_r == OP_RAISE && match) begin
      we = 1'b1;
    end else if (cmd.step && op_r == OP_CLEAR && !remove) begin
      // compaction: kept records slide down to the write pointer
      we    = 1'b1;
      waddr = w_r[IW-1:0];
      wdata = rdata;
    end else if (cmd.append && !full) begin
      we    = 1'b1;
      waddr = used_r[IW-1:0];
      wdata = fresh;
    end
  end

  always_comb begin
    sts.op         = op_r;
    sts.code_zero  = (item_r.code == 16'd0);
    sts.empty      = (used_r == '0);
    sts.last       = ({1'b0, idx_r} + (CW+1)'(1)) >= {1'b0, used_r};
    sts.hit        = (op_r == OP_RAISE) ? match : seq_hit;
    sts.slot_ok    = (target_r < 32'(used_r));
    sts.first_zero = (first_r == 32'd0);
    sts.out_free   = !out_valid_r || out_ready;
  end

  // item and scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r               <= in_op;
      item_r.source      <= in_data[7:0];
      item_r.code        <= in_data[23:8];
      item_r.site        <= in_data[39:24];
      item_r.severity    <= in_data[42:40];
      item_r.epoch       <= in_data[74:43];
      item_r.parent      <= in_data[106:75];
      item_r.args        <= in_data[170:107];
      item_r.arg3        <= in_data[202:171];
      item_r.seq         <= 32'd0;
      item_r.occ         <= 32'd0;
      item_r.lctl        <= in_data[234:203];
      item_r.lts         <= in_data[266:235];
      target_r           <= in_data[298:267];
    end
    if (cmd.scan_init) begin
      idx_r     <= '0;
      w_r       <= '0;
      changed_r <= 1'b0;
      root_r    <= 1'b0;
      rmin_r    <= 32'd0;
      kept0_r   <= 32'd0;
    end
    if (cmd.step) begin
      idx_r <= idx_r + CW'(1);
      if (op_r == OP_CLEAR) begin
        if (remove) begin
          changed_r <= 1'b1;
        end else begin
          w_r <= w_r + CW'(1);
          if (w_r == '0) begin
            kept0_r <= rdata.seq;
          end
          if (rdata.parent == 32'd0 && (!root_r || rdata.seq < rmin_r)) begin
            root_r <= 1'b1;
            rmin_r <= rdata.seq;
          end
        end
      end
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      if (op_r == OP_RAISE) begin
        res_r    <= upd;
        res_ok_r <= 1'b1;
      end else begin
        res_r    <= rdata;
        res_ok_r <= 1'b1;
      end
    end else if (cmd.append) begin
      res_r    <= full ? rec_t'('0) : fresh;
      res_ok_r <= !full;
    end else if (cmd.clr_end) begin
      res_r    <= '0;
      res_ok_r <= changed_r;
    end else if (cmd.fail) begin
      res_r    <= '0;
      res_ok_r <= 1'b0;
    end
  end

  // table bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      drop_r  <= 32'd0;
      next_r  <= 32'd1;
      first_r <= 32'd0;
    end else if (cmd.append) begin
      if (full) begin
        drop_r <= sat_inc(drop_r);
      end else begin
        used_r <= used_r + CW'(1);
        next_r <= (next_r == SEQ_MAX) ? 32'd1 : next_r + 32'd1;
        if (first_r == 32'd0) begin
          first_r <= next_r;
        end
      end
    end else if (cmd.clr_end) begin
      used_r <= w_r;
      if (root_r) begin
        first_r <= rmin_r;
      end else if (w_r != '0) begin
        first_r <= kept0_r;
      end else begin
        first_r <= 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ok_r   <= res_ok_r;
      out_data_r <= {drop_r, 5'(used_r), res_r.parent, res_r.severity, res_r.site,
                     res_r.code, res_r.source, res_r.lts, res_r.lctl, res_r.occ,
                     res_r.seq};
    end
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/fault_record_table_top.sv =====
// Fault log with RECORD_SLOTS records held in one registered-read RAM. One item
// is processed at a time. A raise scans held records slot by slot (RAM read,
// then compare); a clear reads and compacts every held record the same way;
// a read of the first fault scans until the hit. The next item is taken
// while a result still waits on the output register. No clearing pass:
// record storage is only read below the held count.
module fault_record_table_top
  import frt_pkg::*;
#(
  parameter int RECORD_SLOTS = SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // source, code, site, severity, epoch, parent seq, arg pair,
  // third arg, control seq, timestamp, target; zero fill
  input  logic [303:0] in_tdata,
  // operation
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // record seq, occurrences, last control seq, last timestamp,
  // source, code, site, severity, parent, stored count,
  // drop total
  output logic [239:0] out_tdata,
  // ok
  output logic         out_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [2:0] unclr_r;
  cmd_t       cmd;
  sts_t       sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {29'd0, unclr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unclr_r <= UNCLR_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      unclr_r <= pwdata[2:0];
    end
  end

  frt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  frt_dp #(.RECORD_SLOTS(RECORD_SLOTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .unclr     (unclr_r),
    .in_op     (in_tuser),
    .in_data   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_ok    (out_tuser),
    .out_data  (out_tdata)
  );

endmodule

// ===== rtl/core/frt_checker.sv =====
`include "fault_record_table_top_macros.svh"

module frt_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [239:0] out_tdata,
  input logic         out_tuser
);

  `FRT_ASSERT_IMP(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    ##1 out_tvalid, "result item dropped while stalled")
  `FRT_ASSERT_IMP(a_fail_zero, clk, rst_n, out_tvalid && !out_tuser,
    out_tdata[202:0] == 203'd0, "failed item carries record fields")
  `FRT_ASSERT_IMP(a_seq_set, clk, rst_n, out_tvalid && out_tdata[63:32] != 32'd0,
    out_tdata[31:0] != 32'd0 && out_tuser, "record without sequence")

endmodule

bind fault_record_table_top frt_checker u_frt_checker (.*);

// ===== bench/fault_record_table_top_tb.sv =====
`timescale 1ns / 1ps

module fault_record_table_top_tb
  import frt_pkg::*;
;

  localparam int NSLOT = 16;

  typedef struct packed {
    bit [1:0]  op;
    bit [7:0]  src;
    bit [15:0] code;
    bit [15:0] site;
    bit [2:0]  sev;
    bit [31:0] epoch;
    bit [31:0] parent;
    bit [63:0] args;
    bit [31:0] arg3;
    bit [31:0] ctl;
    bit [31:0] ts;
    bit [31:0] target;
  } fault_item_t;

  typedef struct packed {
    bit [7:0]  src;
    bit [15:0] code;
    bit [15:0] site;
    bit [2:0]  sev;
    bit [31:0] epoch;
    bit [31:0] parent;
    bit [63:0] args;
    bit [31:0] arg3;
    bit [31:0] seq;
    bit [31:0] occ;
    bit [31:0] lctl;
    bit [31:0] lts;
  } fault_rec_t;

  typedef struct packed {
    bit        ok;
    bit [31:0] seq;
    bit [31:0] occ;
    bit [31:0] lctl;
    bit [31:0] lts;
    bit [7:0]  src;
    bit [15:0] code;
    bit [15:0] site;
    bit [2:0]  sev;
    bit [31:0] parent;
    bit [4:0]  stored;
    bit [31:0] drop;
  } fault_report_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // source, code, site, severity, epoch, parent seq, arg pair,
  // third arg, control seq, timestamp, target; zero fill
  logic [303:0] in_tdata = '0;
  // operation
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // record seq, occurrences, last control seq, last timestamp,
  // source, code, site, severity, parent, stored count,
  // drop total
  logic [239:0] out_tdata;
  // ok
  logic         out_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  fault_record_table_top DUT (.*);

  always #5 clk = ~clk;

  // model state
  fault_rec_t    log_tbl[NSLOT];
  int unsigned   log_used;
  bit [31:0]     log_drops;
  bit [31:0]     log_next_seq;
  bit [31:0]     log_first_seq;
  bit [2:0]      unclr_sev;

  fault_report_t pending_reports[$];
  fault_item_t   id_pool[8];
  int            send_idle_pct;
  int            recv_idle_pct;
  int            fail_count;
  int            mismatch_count;

  function automatic fault_report_t report_slot(int i);
    fault_report_t r;
    r = '0;
    r.ok = 1'b1;
    r.seq = log_tbl[i].seq;
    r.occ = log_tbl[i].occ;
    r.lctl = log_tbl[i].lctl;
    r.lts = log_tbl[i].lts;
    r.src = log_tbl[i].src;
    r.code = log_tbl[i].code;
    r.site = log_tbl[i].site;
    r.sev = log_tbl[i].sev;
    r.parent = log_tbl[i].parent;
    return r;
  endfunction

  function automatic fault_report_t apply_fault_item(fault_item_t it);
    fault_report_t r;
    fault_rec_t    nr;
    int            w;
    bit            hit;
    bit            changed;
    r = '0;
    hit = 1'b0;
    changed = 1'b0;
    case (it.op)
      OP_RAISE: begin
        if (it.code != 0) begin
          for (int i = 0; i < log_used; i++) begin
            if (log_tbl[i].src == it.src && log_tbl[i].code == it.code &&
                log_tbl[i].site == it.site && log_tbl[i].sev == it.sev &&
                log_tbl[i].epoch == it.epoch && log_tbl[i].parent == it.parent &&
                log_tbl[i].args == it.args && log_tbl[i].arg3 == it.arg3) begin
              if (log_tbl[i].occ != SEQ_MAX) log_tbl[i].occ++;
              log_tbl[i].lctl = it.ctl;
              log_tbl[i].lts = it.ts;
              r = report_slot(i);
              hit = 1'b1;
              break;
            end
          end
          if (!hit) begin
            if (log_used >= NSLOT) begin
              if (log_drops != SEQ_MAX) log_drops++;
            end else begin
              nr = '0;
              nr.src = it.src; nr.code = it.code; nr.site = it.site;
              nr.sev = it.sev; nr.epoch = it.epoch; nr.parent = it.parent;
              nr.args = it.args; nr.arg3 = it.arg3;
              nr.seq = log_next_seq; nr.occ = 1;
              nr.lctl = it.ctl; nr.lts = it.ts;
              log_next_seq++;
              if (log_next_seq == 0) log_next_seq = 1;
              if (log_first_seq == 0) log_first_seq = nr.seq;
              log_tbl[log_used] = nr;
              r = report_slot(int'(log_used));
              log_used++;
            end
          end
        end
      end
      OP_CLEAR: begin
        w = 0;
        for (int i = 0; i < log_used; i++) begin
          if ((it.target == 0 || it.target == log_tbl[i].seq) &&
              log_tbl[i].sev != unclr_sev) begin
            changed = 1'b1;
          end else begin
            log_tbl[w] = log_tbl[i];
            w++;
          end
        end
        log_used = w;
        // root-cause records win; else the oldest slot
        log_first_seq = 0;
        for (int i = 0; i < log_used; i++)
          if (log_tbl[i].parent == 0 &&
              (log_first_seq == 0 || log_tbl[i].seq < log_first_seq))
            log_first_seq = log_tbl[i].seq;
        if (log_first_seq == 0 && log_used != 0) log_first_seq = log_tbl[0].seq;
        r.ok = changed;
      end
      OP_RDFIRST: begin
        if (log_first_seq != 0)
          for (int i = 0; i < log_used; i++)
            if (log_tbl[i].seq == log_first_seq) begin
              r = report_slot(i);
              break;
            end
      end
      default: begin
        if (it.target < log_used) r = report_slot(int'(it.target));
      end
    endcase
    r.stored = 5'(log_used);
    r.drop = log_drops;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    fault_report_t got;
    fault_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.ok = out_tuser;
      got.seq = out_tdata[31:0];
      got.occ = out_tdata[63:32];
      got.lctl = out_tdata[95:64];
      got.lts = out_tdata[127:96];
      got.src = out_tdata[135:128];
      got.code = out_tdata[151:136];
      got.site = out_tdata[167:152];
      got.sev = out_tdata[170:168];
      got.parent = out_tdata[202:171];
      got.stored = out_tdata[207:203];
      got.drop = out_tdata[239:208];
      if (pending_reports.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch:\n  expected %p\n  actual   %p", want, got);
        end
      end
    end
  end

  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic send_item(fault_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.op;
    in_tdata <= {5'd0, it.target, it.ts, it.ctl, it.arg3, it.args, it.parent,
                 it.epoch, it.sev, it.site, it.code, it.src};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_reports.push_back(apply_fault_item(it));
  endtask

  task automatic drain_log;
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    // all sent items have reported; idle before the next test
    repeat (60) @(posedge clk);
  endtask

  task automatic set_unclearable(bit [2:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= '0; pwdata <= {29'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    unclr_sev = v;
  endtask

  function automatic fault_item_t rand_item();
    fault_item_t it;
    it.op = OP_RAISE;
    it.src = 8'($urandom); it.code = 16'($urandom); it.site = 16'($urandom);
    it.sev = 3'($urandom); it.epoch = $urandom; it.parent = $urandom;
    it.args = {$urandom, $urandom}; it.arg3 = $urandom;
    it.ctl = $urandom; it.ts = $urandom; it.target = $urandom;
    if ($urandom_range(1)) it.parent = 0;
    return it;
  endfunction

  function automatic fault_item_t mixed_item();
    fault_item_t it;
    int pick;
    it = rand_item();
    pick = $urandom_range(99);
    if (pick < 55) begin
      if (pick < 30) begin
        it = id_pool[$urandom_range(7)];
        it.ctl = $urandom; it.ts = $urandom; it.target = $urandom;
      end else if (pick < 36) begin
        it.code = 0;
      end
      it.op = OP_RAISE;
    end else if (pick < 65) begin
      it.op = OP_CLEAR;
      pick = $urandom_range(9);
      if (pick < 3) it.target = 0;
      else if (pick < 8 && log_used > 0)
        it.target = log_tbl[$urandom_range(log_used - 1)].seq;
    end else if (pick < 80) begin
      it.op = OP_RDFIRST;
    end else begin
      it.op = OP_RDSLOT;
      if ($urandom_range(9) != 0) it.target = $urandom_range(NSLOT + 1);
    end
    return it;
  endfunction

  task automatic test_directed;
    fault_item_t it;
    fault_item_t a;
    it = rand_item(); it.op = OP_RDFIRST; send_item(it);
    it.op = OP_RDSLOT; it.target = 0; send_item(it);
    it.op = OP_CLEAR; it.target = 0; send_item(it);
    it = rand_item(); it.code = 0; send_item(it);
    // all-ones and all-zeros identities (nonzero code)
    it = '1; it.op = OP_RAISE; send_item(it);
    send_item(it);
    it = '0; it.code = 1; send_item(it);
    a = rand_item(); a.parent = 32'h1234; a.sev = unclr_sev; send_item(a);
    a.ctl = 32'hFFFF_FFFF; a.ts = 0; send_item(a);
    it = rand_item(); it.parent = 0; send_item(it);
    it.op = OP_RDFIRST; send_item(it);
    it.op = OP_RDSLOT; it.target = 3; send_item(it);
    it.target = 32'hFFFF_FFFF; send_item(it);
    it.target = 4; send_item(it);
    it.op = OP_CLEAR; it.target = 32'hDEAD_0000; send_item(it);
    it.target = 2; send_item(it);
    it.op = OP_RDFIRST; send_item(it);
    it.op = OP_CLEAR; it.target = 0; send_item(it);
    it.op = OP_RDSLOT; it.target = 0; send_item(it);
    it.op = OP_RDFIRST; send_item(it);
    it.op = OP_CLEAR; it.target = 0; send_item(it);
    a.op = OP_RAISE; send_item(a);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < 8; i++) begin
      id_pool[i] = rand_item();
      if (id_pool[i].code == 0) id_pool[i].code = 16'h8001;
      if (i < 2) id_pool[i].sev = unclr_sev;
    end
    for (int n = 0; n < count; n++) send_item(mixed_item());
    drain_log();
  endtask

  initial begin
    log_used = 0; log_drops = 0; log_next_seq = 1; log_first_seq = 0;
    unclr_sev = UNCLR_RST;
    fail_count = 0; mismatch_count = 0;
    send_idle_pct = 32; recv_idle_pct = 48;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain_log();
    test_random(310);
    set_unclearable(3'd0);
    send_idle_pct = 48; recv_idle_pct = 32;
    test_random(310);
    set_unclearable(3'd7);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(200);
    set_unclearable(3'($urandom));
    test_random(110);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/frt_pkg.sv
rtl/core/frt_ram.sv
rtl/core/frt_ctrl.sv
rtl/core/frt_dp.sv
rtl/core/fault_record_table_top.sv
rtl/core/frt_checker.sv
bench/fault_record_table_top_tb.sv
